// ----- hdl/bclru_pkg.sv -----
// Shared types and constants for the buffer cache tag and replacement engine.
package bclru_pkg;

	localparam logic [31:0] LAST_USE_NONE = 32'hFFFF_FFFF;
	localparam logic [7:0]  REFS_MAX      = 8'hFF;
	localparam logic [7:0]  REFS_ONE      = 8'h01;

	typedef enum logic [1:0] {
		ACT_ACQUIRE = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_PIN     = 2'd2,
		ACT_UNPIN   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STS_HIT       = 2'd0,
		STS_MISS      = 2'd1,
		STS_FULL      = 2'd2,
		STS_COUNT_ERR = 2'd3
	} status_t;

	typedef struct packed {
		action_t     action;
		logic [7:0]  device;
		logic [31:0] block_number;
		logic [4:0]  buffer_slot;
		logic [31:0] tick;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [4:0] slot;
		logic       needs_read;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  device;
		logic [31:0] block_number;
		logic [7:0]  refs;
		logic [31:0] last_use;
		logic        data_valid;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_SLOT_RD,
		S_UPDATE
	} state_t;

endpackage

// ----- hdl/block_buffer_cache_lru_unit.sv -----
// Top level of the buffer cache tag and replacement engine.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  req     | in        | req_valid / req_ready | action, device, block, slot, tick
//  rsp     | out       | rsp_valid / rsp_ready | status, slot, needs_read
//
// Acquire: the entry memory is swept one entry a cycle through one tag/last-use
// compare unit, its registered read port setting the pace.
// Release, pin and unpin: at most one read and one write of the entry.
// Reset clears the per-entry written bits at once; unwritten entries read as zero.
// The result sits in an output register; only a new result waits on rsp_ready.
module block_buffer_cache_lru_unit
	import bclru_pkg::*;
#(
	parameter int BUF_COUNT = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int IW = (BUF_COUNT > 1) ? $clog2(BUF_COUNT) : 1;

	state_t state_q, state_d;

	// request captured at transfer
	action_t     act_q;
	logic [7:0]  dev_q;
	logic [31:0] blk_q;
	logic [31:0] tick_q;
	logic [IW-1:0] slot_q;
	logic        range_err_q;

	// entry store: memory plus one written bit per entry
	entry_t mem_q [BUF_COUNT];
	logic [BUF_COUNT-1:0] written_q;
	entry_t   rd_data_q;
	logic     rd_wr_q;
	entry_t   rd_ent;

	// sequencer controls
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          upd_go;
	logic          scan_last;
	logic [IW-1:0] scan_q;

	// compare pipeline stage
	logic          cmp_vld_s1;
	logic [IW-1:0] cmp_idx_s1;

	// scan results
	logic          hit_found_q;
	logic [IW-1:0] hit_idx_q;
	entry_t        hit_ent_q;
	logic          pick_found_q;
	logic [IW-1:0] pick_idx_q;
	logic [31:0]   best_q;

	// update datapath
	logic          we;
	logic [IW-1:0] waddr;
	entry_t        wdata;
	rsp_t          result;

	logic rsp_valid_q;
	rsp_t rsp_q;
	logic out_free;
	logic accept;
	logic slot_oob;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign scan_last = (scan_q == IW'(BUF_COUNT - 1));
	assign slot_oob  = (9'(req.buffer_slot) >= 9'(BUF_COUNT));
	assign rd_ent    = rd_wr_q ? rd_data_q : '0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (req.action == ACT_ACQUIRE) begin
						state_d = S_SCAN;
					end else if (slot_oob) begin
						state_d = S_UPDATE;
					end else begin
						state_d = S_SLOT_RD;
					end
				end
			end
			S_SCAN: begin
				if (scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN:   state_d = S_UPDATE;
			S_SLOT_RD: state_d = S_UPDATE;
			S_UPDATE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req_ready = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = scan_q;
		upd_go    = 1'b0;
		case (state_q)
			S_IDLE:  req_ready = 1'b1;
			S_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = scan_q;
			end
			S_SLOT_RD: begin
				rd_en   = 1'b1;
				rd_addr = slot_q;
			end
			S_UPDATE: upd_go = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request capture and sweep counter
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q       <= req.action;
			dev_q       <= req.device;
			blk_q       <= req.block_number;
			tick_q      <= req.tick;
			slot_q      <= IW'(req.buffer_slot);
			range_err_q <= slot_oob;
			scan_q      <= '0;
		end else if (state_q == S_SCAN) begin
			scan_q <= scan_q + 1'b1;
		end
	end

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
			rd_wr_q   <= written_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q  <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			if (we) begin
				written_q[waddr] <= 1'b1;
			end
			cmp_vld_s1 <= (state_q == S_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= scan_q;
	end

	// shared compare unit: later tag match overrides, strict less keeps lowest index
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_found_q  <= 1'b0;
			pick_found_q <= 1'b0;
			best_q       <= LAST_USE_NONE;
		end else if (cmp_vld_s1) begin
			if (rd_ent.device == dev_q && rd_ent.block_number == blk_q) begin
				hit_found_q <= 1'b1;
				hit_idx_q   <= cmp_idx_s1;
				hit_ent_q   <= rd_ent;
			end
			if (rd_ent.refs == 8'd0 && rd_ent.last_use < best_q) begin
				pick_found_q <= 1'b1;
				pick_idx_q   <= cmp_idx_s1;
				best_q       <= rd_ent.last_use;
			end
		end
	end

	// update and result
	always_comb begin
		we     = 1'b0;
		waddr  = slot_q;
		wdata  = rd_ent;
		result = '{status: STS_COUNT_ERR, slot: 5'd0, needs_read: 1'b0};
		case (act_q)
			ACT_ACQUIRE: begin
				if (hit_found_q) begin
					if (hit_ent_q.refs != REFS_MAX) begin
						waddr            = hit_idx_q;
						wdata            = hit_ent_q;
						wdata.refs       = hit_ent_q.refs + 8'd1;
						wdata.data_valid = 1'b1;
						we               = upd_go;
						result = '{status: STS_HIT, slot: 5'(hit_idx_q),
							needs_read: !hit_ent_q.data_valid};
					end
				end else if (pick_found_q) begin
					waddr  = pick_idx_q;
					wdata  = '{device: dev_q, block_number: blk_q, refs: REFS_ONE,
						last_use: tick_q, data_valid: 1'b1};
					we     = upd_go;
					result = '{status: STS_MISS, slot: 5'(pick_idx_q), needs_read: 1'b1};
				end else begin
					result.status = STS_FULL;
				end
			end
			ACT_PIN: begin
				if (!range_err_q && rd_ent.refs != REFS_MAX) begin
					wdata.refs    = rd_ent.refs + 8'd1;
					we            = upd_go;
					result.status = STS_HIT;
				end
			end
			ACT_RELEASE, ACT_UNPIN: begin
				if (!range_err_q && rd_ent.refs != 8'd0) begin
					wdata.refs = rd_ent.refs - 8'd1;
					if (act_q == ACT_RELEASE) begin
						wdata.last_use = tick_q;
					end
					we            = upd_go;
					result.status = STS_HIT;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (upd_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- hdl/bclru_checker.sv -----
// Port-level checks for the buffer cache engine, bound to the top level.
module bclru_checker
	import bclru_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// a pending result holds until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result dropped or changed while stalled");

	// the block is busy right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken on consecutive cycles");

	// failed results carry no slot and no read request
	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STS_FULL || rsp.status == STS_COUNT_ERR)
		|-> rsp.slot == 5'd0 && !rsp.needs_read)
		else $error("error result with slot or needs_read set");

	// a fresh allocation always needs a disk read
	a_miss_read: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STS_MISS |-> rsp.needs_read)
		else $error("miss without needs_read");

endmodule

bind block_buffer_cache_lru_unit bclru_checker u_bclru_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the buffer cache tag and LRU replacement engine.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bclru_pkg::*;

	localparam int BUFS = 32;   // entries in the cache under test
	localparam int POOL = 48;   // reusable tags, more than the entries so eviction occurs

	// Tracks the cache's tag store, reference counts and last-use stamps, and
	// holds the results expected back from the block, oldest first.
	class cache_tag_tracker;
		logic [7:0]  dev_tag [BUFS];
		logic [31:0] blk_tag [BUFS];
		logic [7:0]  ref_cnt [BUFS];
		logic [31:0] used_at [BUFS];
		bit          data_ok [BUFS];
		rsp_t        awaited_results [$];
		int          results_checked;
		int          failures;
		int          status_seen [4];

		function new();
			int i;
			for (i = 0; i < BUFS; i++) begin
				dev_tag[i] = '0;
				blk_tag[i] = '0;
				ref_cnt[i] = '0;
				used_at[i] = '0;
				data_ok[i] = 1'b0;
			end
			for (i = 0; i < 4; i++)
				status_seen[i] = 0;
			results_checked = 0;
			failures = 0;
		endfunction

		// Applies one request to the tracked state and returns what the block
		// should answer. The slot field is 5 bits wide and there are 32 entries,
		// so an out-of-range slot cannot be requested.
		function rsp_t grant_for(req_t r);
			rsp_t        res;
			int          i;
			int          hit;
			int          pick;
			logic [31:0] best;
			res = '0;
			res.status = STS_COUNT_ERR;
			hit = -1;
			pick = -1;
			best = LAST_USE_NONE;
			case (r.action)
				ACT_ACQUIRE: begin
					// last match wins, so duplicate tags resolve to the highest index
					for (i = 0; i < BUFS; i++)
						if (dev_tag[i] == r.device && blk_tag[i] == r.block_number)
							hit = i;
					if (hit >= 0) begin
						if (ref_cnt[hit] != REFS_MAX) begin
							ref_cnt[hit] = ref_cnt[hit] + 8'd1;
							res.status = STS_HIT;
							res.slot = 5'(hit);
							res.needs_read = !data_ok[hit];
							data_ok[hit] = 1'b1;
						end
					end else begin
						// strict less-than: lowest index wins a tie, all-ones never qualifies
						for (i = 0; i < BUFS; i++)
							if (ref_cnt[i] == 8'd0 && used_at[i] < best) begin
								best = used_at[i];
								pick = i;
							end
						if (pick >= 0) begin
							dev_tag[pick] = r.device;
							blk_tag[pick] = r.block_number;
							ref_cnt[pick] = REFS_ONE;
							used_at[pick] = r.tick;
							data_ok[pick] = 1'b1;
							res.status = STS_MISS;
							res.slot = 5'(pick);
							res.needs_read = 1'b1;
						end else begin
							res.status = STS_FULL;
						end
					end
				end
				ACT_PIN: begin
					if (ref_cnt[r.buffer_slot] != REFS_MAX) begin
						ref_cnt[r.buffer_slot] = ref_cnt[r.buffer_slot] + 8'd1;
						res.status = STS_HIT;
					end
				end
				default: begin
					// release and unpin; only release stamps the last-use tick
					if (ref_cnt[r.buffer_slot] != 8'd0) begin
						ref_cnt[r.buffer_slot] = ref_cnt[r.buffer_slot] - 8'd1;
						if (r.action == ACT_RELEASE)
							used_at[r.buffer_slot] = r.tick;
						res.status = STS_HIT;
					end
				end
			endcase
			return res;
		endfunction

		function void note_request(req_t r);
			awaited_results.push_back(grant_for(r));
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (awaited_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("result with nothing awaited: status %0d slot %0d needs_read %0b",
						got.status, got.slot, got.needs_read);
				return;
			end
			want = awaited_results.pop_front();
			results_checked++;
			status_seen[got.status]++;
			if (got.status !== want.status || got.slot !== want.slot ||
					got.needs_read !== want.needs_read) begin
				failures++;
				if (failures <= 10)
					$display("result %0d wrong: status %0d/%0d slot %0d/%0d needs_read %0b/%0b %s",
						results_checked, want.status, got.status, want.slot, got.slot,
						want.needs_read, got.needs_read, "(expected/actual)");
			end
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		// entries a miss could still take
		function int free_slots();
			int i;
			int n;
			n = 0;
			for (i = 0; i < BUFS; i++)
				if (ref_cnt[i] == 8'd0 && used_at[i] != LAST_USE_NONE)
					n++;
			return n;
		endfunction

		// a random entry with a non-zero count, or -1
		function int pick_held();
			int i;
			int held [$];
			for (i = 0; i < BUFS; i++)
				if (ref_cnt[i] != 8'd0)
					held.push_back(i);
			if (held.size() == 0)
				return -1;
			return held[$urandom_range(held.size() - 1)];
		endfunction

		function int find_tag(logic [7:0] dev, logic [31:0] blk);
			int i;
			int hit;
			hit = -1;
			for (i = 0; i < BUFS; i++)
				if (dev_tag[i] == dev && blk_tag[i] == blk)
					hit = i;
			return hit;
		endfunction

		function logic [7:0] refs_of(int i);
			return ref_cnt[i];
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	cache_tag_tracker tracker = new();

	int          items_sent = 0;
	logic [31:0] now_tick = 32'd100;
	logic [7:0]  pool_dev [POOL];
	logic [31:0] pool_blk [POOL];
	int          stall_left = 0;   // receiver hold-off, counted down in its own process
	bit          stalled_once = 1'b0;

	block_buffer_cache_lru_unit #(
		.BUF_COUNT(BUFS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit: far beyond the slowest legal run (about 500 requests at
	// acquire latency plus idling and the long receiver hold-off).
	initial begin
		#1_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Mostly a steadily advancing tick; now and then an arbitrary value or the
	// all-ones stamp that keeps a free entry from being chosen.
	function automatic logic [31:0] fresh_tick();
		int roll;
		roll = $urandom_range(99);
		if (roll < 85) begin
			now_tick = now_tick + 32'($urandom_range(40, 1));
			return now_tick;
		end else if (roll < 95) begin
			return $urandom;
		end
		return LAST_USE_NONE;
	endfunction

	// Both sides run without idling for a stretch in the middle of the run.
	function automatic bit sender_idles();
		if (items_sent >= 250 && items_sent < 400)
			return 1'b0;
		return $urandom_range(99) < 30;
	endfunction

	// Drives one request, waits for its transfer, then idles at random.
	// Entered and left at a falling edge; valid is written once per step.
	task automatic send_req(input req_t r);
		req = r;
		req_valid = 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		tracker.note_request(r);
		items_sent++;
		@(negedge clk);
		while (sender_idles()) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
	endtask

	// Acquire; the slot field is don't-care and gets random bits.
	task automatic request_block(input logic [7:0] dev, input logic [31:0] blk,
			input logic [31:0] tk);
		req_t r;
		r.action = ACT_ACQUIRE;
		r.device = dev;
		r.block_number = blk;
		r.buffer_slot = 5'($urandom_range(31));
		r.tick = tk;
		send_req(r);
	endtask

	// Release, pin or unpin; the tag fields are don't-care and get random bits.
	task automatic slot_command(input action_t act, input logic [4:0] s,
			input logic [31:0] tk);
		req_t r;
		r.action = act;
		r.device = 8'($urandom_range(255));
		r.block_number = $urandom;
		r.buffer_slot = s;
		r.tick = tk;
		send_req(r);
	endtask

	// Random traffic: acquires mostly from the tag pool so hits are common,
	// releases aimed at held entries, plus stray pins, unpins and releases.
	task automatic random_mix(input int n);
		int roll;
		int k;
		int s;
		repeat (n) begin
			roll = $urandom_range(99);
			if (roll < 45) begin
				if ($urandom_range(99) < 85) begin
					k = $urandom_range(POOL - 1);
					request_block(pool_dev[k], pool_blk[k], fresh_tick());
				end else begin
					request_block(8'($urandom_range(255)), $urandom, fresh_tick());
				end
			end else if (roll < 75) begin
				s = tracker.pick_held();
				if (s < 0)
					s = $urandom_range(BUFS - 1);
				slot_command(ACT_RELEASE, 5'(s), fresh_tick());
			end else if (roll < 85) begin
				slot_command(ACT_PIN, 5'($urandom_range(BUFS - 1)), fresh_tick());
			end else if (roll < 95) begin
				s = tracker.pick_held();
				if (s < 0 || $urandom_range(1) == 0)
					s = $urandom_range(BUFS - 1);
				slot_command(ACT_UNPIN, 5'(s), fresh_tick());
			end else begin
				slot_command(ACT_RELEASE, 5'($urandom_range(BUFS - 1)), fresh_tick());
			end
		end
	endtask

	// Receiver: ready drops at random, except in the quiet stretch and during
	// the one long hold-off, which starts after the hundredth result.
	initial begin
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready = 1'b0;
			end else if (tracker.results_checked >= 250 && tracker.results_checked < 400) begin
				rsp_ready = 1'b1;
			end else begin
				rsp_ready = $urandom_range(99) >= 30;
			end
			@(posedge clk);
			if (arst_n && rsp_valid && rsp_ready) begin
				tracker.check_result(rsp);
				if (tracker.results_checked == 100 && !stalled_once) begin
					stalled_once = 1'b1;
					stall_left = 400;
				end
			end
		end
	end

	initial begin
		int          i;
		int          s;
		logic [7:0]  dev;
		logic [31:0] blk;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed part ---
		// every entry carries tag (0,0) after reset: the highest index matches
		request_block(8'h00, 32'h0000_0000, 32'd5);       // hit 31, read needed
		request_block(8'h00, 32'h0000_0000, 32'd6);       // hit 31, data now valid
		// all free entries tie at zero: lowest index taken, stamped all-ones
		request_block(8'hFF, 32'hFFFF_FFFF, LAST_USE_NONE);
		slot_command(ACT_RELEASE, 5'd0, LAST_USE_NONE);   // entry 0 free but never eligible
		request_block(8'h01, 32'h1234_5678, 32'd10);      // miss skips entry 0
		request_block(8'hFF, 32'hFFFF_FFFF, 32'd11);      // hit on a free entry keeps its data
		slot_command(ACT_UNPIN, 5'd0, 32'd12);
		slot_command(ACT_UNPIN, 5'd5, 32'd13);            // count already zero
		slot_command(ACT_RELEASE, 5'd6, 32'd14);          // count already zero
		slot_command(ACT_PIN, 5'd7, 32'd15);
		slot_command(ACT_UNPIN, 5'd7, 32'd16);
		slot_command(ACT_PIN, 5'd31, 32'd17);
		slot_command(ACT_RELEASE, 5'd31, 32'd18);
		slot_command(ACT_RELEASE, 5'd31, 32'd19);
		slot_command(ACT_RELEASE, 5'd31, 32'd20);
		slot_command(ACT_RELEASE, 5'd31, 32'd21);         // one release too many
		slot_command(ACT_RELEASE, 5'd1, 32'd0);           // entry 1 free with tick zero
		request_block(8'h80, 32'h8000_0000, 32'd22);      // tie at zero, lowest index wins
		request_block(8'h00, 32'h0000_0000, 32'd23);      // hit 31 again from free

		for (i = 0; i < POOL; i++) begin
			pool_dev[i] = 8'($urandom_range(255));
			pool_blk[i] = $urandom;
		end
		pool_dev[0] = 8'h00;
		pool_blk[0] = 32'h0000_0000;
		pool_dev[1] = 8'hFF;
		pool_blk[1] = 32'hFFFF_FFFF;

		random_mix(30);

		// --- exhaustion: hold every entry a miss could take, then free them all at all-ones ---
		while (tracker.free_slots() > 0)
			request_block(8'($urandom_range(255)), $urandom, fresh_tick());
		request_block(8'($urandom_range(255)), $urandom, fresh_tick());  // nothing eligible
		for (i = 0; i < BUFS; i++)
			while (tracker.refs_of(i) != 8'd0)
				slot_command(ACT_RELEASE, 5'(i), LAST_USE_NONE);
		request_block(8'($urandom_range(255)), $urandom, fresh_tick());  // none eligible
		// a pin and release restamps each entry with an ordinary tick
		for (i = 0; i < BUFS; i++) begin
			slot_command(ACT_PIN, 5'(i), fresh_tick());
			now_tick = now_tick + 32'd1;
			slot_command(ACT_RELEASE, 5'(i), now_tick);
		end

		// --- count saturation on a freshly tagged entry, left held at full count ---
		dev = 8'($urandom_range(255));
		blk = $urandom;
		request_block(dev, blk, fresh_tick());
		s = tracker.find_tag(dev, blk);
		if (s >= 0) begin
			while (tracker.refs_of(s) != REFS_MAX)
				slot_command(ACT_PIN, 5'(s), fresh_tick());
			slot_command(ACT_PIN, 5'(s), fresh_tick());      // pin at full count
			request_block(dev, blk, fresh_tick());           // hit at full count
		end

		random_mix(40);

		@(negedge clk);
		req_valid = 1'b0;
		while (tracker.pending() > 0)
			@(posedge clk);
		// acquire latency plus margin, to catch any stray result
		repeat (BUFS + 10) @(posedge clk);

		$display("Ran %0d requests incl. exhaustion and count saturation; %0d results checked",
			items_sent, tracker.results_checked);
		$display("  hits %0d, misses %0d, no free entry %0d, count errors %0d, failures %0d",
			tracker.status_seen[STS_HIT], tracker.status_seen[STS_MISS],
			tracker.status_seen[STS_FULL], tracker.status_seen[STS_COUNT_ERR],
			tracker.failures + tracker.pending());
		if (tracker.failures == 0 && tracker.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
